FILE: rtl/sdt_pkg.sv
// Shared types and constants of the sky dome texture coordinate block.
// Used by every other file of the block; depends on nothing.
package sdt_pkg;

    localparam int POS_W    = 24;
    localparam int DIFF_W   = 25;
    localparam int DZ_W     = 27;
    localparam int SQ_W     = 52;
    localparam int ROOT_IN_W = 60;
    localparam int LEN_W    = 30;
    localparam int SCROLL_W = 15;
    localparam int OUT_W    = 15;
    localparam int NUM_W    = 47;
    localparam int DEN_W    = 33;
    localparam int REM_W    = 49;
    localparam int QUO_W    = 15;
    localparam int KD_W     = 21;
    localparam int CFG_IDX_W = 8;

    localparam int SQRT_STEPS = ROOT_IN_W / 2;

    // 8 * 12096 * 16: the dome constant 378 in the fixed point of the quotient.
    localparam logic [KD_W-1:0] DOME_K = KD_W'(1548288);

    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(16383);
    localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EYE_X  = 8'd0,
        REG_EYE_Y  = 8'd1,
        REG_EYE_Z  = 8'd2,
        REG_SCROLL = 8'd3
    } sdt_reg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     zero;
    } sdt_side_t;

    typedef struct packed {
        logic [ROOT_IN_W-1:0] rem;
        logic [ROOT_IN_W-1:0] res;
        sdt_side_t            side;
    } sdt_root_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             zero;
        logic             sat;
    } sdt_div_t;

endpackage

FILE: rtl/sdt_if.sv
// Handshake channels of the sky dome block: vertex in, texture result out, config write.
// Depends on sdt_pkg for widths.
interface sdt_vtx_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sdt_pkg::POS_W-1:0]     pos_x;
    logic signed [sdt_pkg::POS_W-1:0]     pos_y;
    logic signed [sdt_pkg::POS_W-1:0]     pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface sdt_tex_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sdt_pkg::OUT_W-1:0]     tex_s;
    logic signed [sdt_pkg::OUT_W-1:0]     tex_t;
    logic                                 at_eye;
    modport source (output valid, tex_s, tex_t, at_eye, input ready);
    modport sink   (input valid, tex_s, tex_t, at_eye, output ready);
endinterface

interface sdt_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [sdt_pkg::CFG_IDX_W-1:0]        index;
    logic [sdt_pkg::POS_W-1:0]            data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sky_dome_texcoord.sv
// Top level of the sky dome texture coordinate block: config registers, products, stalls.
// Depends on sdt_pkg, sdt_if, sdt_sq, sdt_sqrt and sdt_div.
//
// Usage: vertex words (pos_x, pos_y, pos_z, Q16.8) enter on the vtx channel and one
// result word (tex_s, tex_t in Q3.12, at_eye) leaves on the tex channel per vertex,
// in order. Eye position and scroll amount are written on the cfg channel, which is
// always ready; write it only while no vertex is in flight.
// Throughput is one vertex per cycle while the result at the output is taken. The
// stages, in order: direction and squared length, the square root (one bit a stage),
// the numerator products and the divider (entry, overflow check, 15 quotient bits,
// clamp).
// The whole pipeline advances as one: when the result at the output is not taken,
// every stage holds and vtx.ready drops, so nothing is lost or repeated. Empty
// stages hold too during a stall, so bubbles are not squeezed out.
// Reset clears all valid bits and sets the eye and scroll registers to zero.
module sky_dome_texcoord (
    input  logic       clk,
    input  logic       rst_n,
    sdt_vtx_if.sink    vtx,
    sdt_tex_if.source  tex,
    sdt_cfg_if.sink    cfg
);
    logic signed [sdt_pkg::POS_W-1:0]    eye_x_reg, eye_y_reg, eye_z_reg;
    logic [sdt_pkg::SCROLL_W-1:0]        scroll_reg;

    logic                                adv;
    logic                                sq_valid, rt_valid, s_valid, t_valid;
    logic [sdt_pkg::SQ_W-1:0]            sq_q;
    logic signed [sdt_pkg::DIFF_W-1:0]   sq_dx, sq_dy;
    sdt_pkg::sdt_side_t                  side_in, side_out;
    logic [sdt_pkg::LEN_W-1:0]           len;

    logic                                pr_valid_reg;
    logic [sdt_pkg::NUM_W-2:0]           ps_reg;
    logic signed [sdt_pkg::NUM_W-1:0]    pdx_reg, pdy_reg;
    logic [sdt_pkg::LEN_W-1:0]           len_reg;
    logic                                zero_reg;
    logic signed [sdt_pkg::NUM_W-1:0]    num_s, num_t;
    logic                                t_zero;
    logic signed [sdt_pkg::OUT_W-1:0]    res_t;

    assign adv       = !s_valid || tex.ready;
    assign vtx.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg  <= '0;
            eye_y_reg  <= '0;
            eye_z_reg  <= '0;
            scroll_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                sdt_pkg::REG_EYE_X:  eye_x_reg  <= cfg.data;
                sdt_pkg::REG_EYE_Y:  eye_y_reg  <= cfg.data;
                sdt_pkg::REG_EYE_Z:  eye_z_reg  <= cfg.data;
                sdt_pkg::REG_SCROLL: scroll_reg <= cfg.data[sdt_pkg::SCROLL_W-1:0];
                default: ;
            endcase
        end
    end

    sdt_sq u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vtx.valid),
        .px        (vtx.pos_x),
        .py        (vtx.pos_y),
        .pz        (vtx.pos_z),
        .ex        (eye_x_reg),
        .ey        (eye_y_reg),
        .ez        (eye_z_reg),
        .out_valid (sq_valid),
        .q         (sq_q),
        .dx        (sq_dx),
        .dy        (sq_dy)
    );

    always_comb
    begin
        side_in.dx   = sq_dx;
        side_in.dy   = sq_dy;
        side_in.zero = (sq_q == '0);
    end

    sdt_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .q         (sq_q),
        .side_in   (side_in),
        .out_valid (rt_valid),
        .len       (len),
        .side_out  (side_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pr_valid_reg <= rt_valid;
        end
    end

    // Numerator is scroll*L + K*d; the two products are registered before the add.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_reg   <= (sdt_pkg::NUM_W-1)'(scroll_reg * len);
            pdx_reg  <= sdt_pkg::NUM_W'(side_out.dx * $signed({1'b0, sdt_pkg::DOME_K}));
            pdy_reg  <= sdt_pkg::NUM_W'(side_out.dy * $signed({1'b0, sdt_pkg::DOME_K}));
            len_reg  <= len;
            zero_reg <= side_out.zero;
        end
    end

    assign num_s = $signed({1'b0, ps_reg}) + pdx_reg;
    assign num_t = $signed({1'b0, ps_reg}) + pdy_reg;

    sdt_div u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pr_valid_reg),
        .num       (num_s),
        .len       (len_reg),
        .zero      (zero_reg),
        .out_valid (s_valid),
        .result    (tex.tex_s),
        .out_zero  (tex.at_eye)
    );

    sdt_div u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pr_valid_reg),
        .num       (num_t),
        .len       (len_reg),
        .zero      (zero_reg),
        .out_valid (t_valid),
        .result    (res_t),
        .out_zero  (t_zero)
    );

    // Both dividers run in lockstep; the t side is qualified with its own flags.
    assign tex.tex_t = (t_valid && !t_zero) ? res_t : '0;
    assign tex.valid = s_valid;
endmodule

FILE: rtl/sdt_sq.sv
// Front stages: eye-relative direction, squares and squared length (three stages).
// Depends on sdt_pkg.
module sdt_sq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [sdt_pkg::POS_W-1:0]    px,
    input  logic signed [sdt_pkg::POS_W-1:0]    py,
    input  logic signed [sdt_pkg::POS_W-1:0]    pz,
    input  logic signed [sdt_pkg::POS_W-1:0]    ex,
    input  logic signed [sdt_pkg::POS_W-1:0]    ey,
    input  logic signed [sdt_pkg::POS_W-1:0]    ez,
    output logic                                out_valid,
    output logic [sdt_pkg::SQ_W-1:0]            q,
    output logic signed [sdt_pkg::DIFF_W-1:0]   dx,
    output logic signed [sdt_pkg::DIFF_W-1:0]   dy
);
    localparam int DW = sdt_pkg::DIFF_W;
    localparam int ZW = sdt_pkg::DZ_W;

    logic [2:0]           v_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [ZW-1:0] dz1_reg;
    logic [2*DW-1:0]      sqx_reg, sqy_reg;
    logic [sdt_pkg::SQ_W-1:0] sqz_reg, q_reg;

    logic signed [DW-1:0] dx1_next, dy1_next, dz_diff;
    logic signed [ZW-1:0] dz1_next;
    logic [DW-1:0]        ax, ay;
    logic [ZW-2:0]        az;
    logic signed [ZW-1:0] dz_abs;

    always_comb
    begin
        dx1_next = DW'(px) - DW'(ex);
        dy1_next = DW'(py) - DW'(ey);
        dz_diff  = DW'(pz) - DW'(ez);
        dz1_next = (ZW'(dz_diff) <<< 1) + ZW'(dz_diff);
        ax = dx1_reg[DW-1] ? DW'(-dx1_reg) : DW'(dx1_reg);
        ay = dy1_reg[DW-1] ? DW'(-dy1_reg) : DW'(dy1_reg);
        dz_abs = dz1_reg[ZW-1] ? -dz1_reg : dz1_reg;
        az = dz_abs[ZW-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            dz1_reg <= dz1_next;
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            sqz_reg <= az * az;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            q_reg   <= sdt_pkg::SQ_W'(sqx_reg) + sdt_pkg::SQ_W'(sqy_reg) + sqz_reg;
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign q  = q_reg;
    assign dx = dx3_reg;
    assign dy = dy3_reg;
endmodule

FILE: rtl/sdt_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on sdt_pkg.
module sdt_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [sdt_pkg::SQ_W-1:0]      q,
    input  sdt_pkg::sdt_side_t            side_in,
    output logic                          out_valid,
    output logic [sdt_pkg::LEN_W-1:0]     len,
    output sdt_pkg::sdt_side_t            side_out
);
    localparam int N  = sdt_pkg::SQRT_STEPS;
    localparam int RW = sdt_pkg::ROOT_IN_W;

    sdt_pkg::sdt_root_t st_reg  [N];
    sdt_pkg::sdt_root_t st_next [N];
    logic [N-1:0]       v_reg;

    always_comb
    begin
        sdt_pkg::sdt_root_t cur;
        logic [RW-1:0]      bitv;
        logic [RW-1:0]      trial;
        for (int i = 0; i < N; i++)
        begin
            if (i == 0)
            begin
                cur.rem  = RW'(q) << 8;
                cur.res  = '0;
                cur.side = side_in;
            end
            else
            begin
                cur = st_reg[i-1];
            end
            bitv  = RW'(1) << (2 * (N - 1 - i));
            trial = cur.res + bitv;
            st_next[i].side = cur.side;
            if (cur.rem >= trial)
            begin
                st_next[i].rem = cur.rem - trial;
                st_next[i].res = (cur.res >> 1) + bitv;
            end
            else
            begin
                st_next[i].rem = cur.rem;
                st_next[i].res = cur.res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign len       = st_reg[N-1].res[sdt_pkg::LEN_W-1:0];
    assign side_out  = st_reg[N-1].side;
endmodule

FILE: rtl/sdt_div.sv
// Pipelined restoring divider with round-to-nearest and output clamp, one bit a stage.
// Depends on sdt_pkg.
module sdt_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [sdt_pkg::NUM_W-1:0]   num,
    input  logic [sdt_pkg::LEN_W-1:0]          len,
    input  logic                               zero,
    output logic                               out_valid,
    output logic signed [sdt_pkg::OUT_W-1:0]   result,
    output logic                               out_zero
);
    localparam int QW = sdt_pkg::QUO_W;
    localparam int RW = sdt_pkg::REM_W;
    // Entry stage, overflow check, one stage per quotient bit.
    localparam int N  = QW + 2;

    sdt_pkg::sdt_div_t st_reg  [N];
    sdt_pkg::sdt_div_t st_next [N];
    logic [N:0]        v_reg;
    logic signed [sdt_pkg::OUT_W-1:0] res_reg, res_next;
    logic              zero_reg;

    always_comb
    begin
        sdt_pkg::sdt_div_t   cur;
        logic [RW-1:0]       dsh;
        logic [sdt_pkg::NUM_W-1:0] mag;
        mag = num[sdt_pkg::NUM_W-1] ? sdt_pkg::NUM_W'(-num) : sdt_pkg::NUM_W'(num);
        // Entry: magnitude plus half the divisor gives rounding to nearest, ties away.
        st_next[0].rem  = RW'(mag) + (RW'(len) << 2);
        st_next[0].den  = sdt_pkg::DEN_W'(len) << 3;
        st_next[0].quo  = '0;
        st_next[0].neg  = num[sdt_pkg::NUM_W-1];
        st_next[0].zero = zero;
        st_next[0].sat  = 1'b0;
        cur = st_reg[0];
        st_next[1] = cur;
        st_next[1].sat = cur.rem >= (RW'(cur.den) << QW);
        for (int i = 2; i < N; i++)
        begin
            cur = st_reg[i-1];
            dsh = RW'(cur.den) << (N - 1 - i);
            st_next[i] = cur;
            if (cur.rem >= dsh)
            begin
                st_next[i].rem = cur.rem - dsh;
                st_next[i].quo = {cur.quo[QW-2:0], 1'b1};
            end
            else
            begin
                st_next[i].quo = {cur.quo[QW-2:0], 1'b0};
            end
        end
        cur = st_reg[N-1];
        if (cur.zero)
        begin
            res_next = '0;
        end
        else if (!cur.neg)
        begin
            res_next = (cur.sat || cur.quo > QW'(16383)) ? sdt_pkg::OUT_MAX
                                                           : sdt_pkg::OUT_W'(cur.quo);
        end
        else
        begin
            res_next = (cur.sat || cur.quo > QW'(16384)) ? sdt_pkg::OUT_MIN
                                                           : sdt_pkg::OUT_W'(-cur.quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            res_reg  <= res_next;
            zero_reg <= st_reg[N-1].zero;
        end
    end

    assign out_valid = v_reg[N];
    assign result    = res_reg;
    assign out_zero  = zero_reg;
endmodule
